>>> rtl/rgb_to_hsv_convert_macros.svh
// Assertion helpers for the colour converter. Both expect clk and rst_n in scope.
`ifndef RGB_TO_HSV_CONVERT_MACROS_SVH
`define RGB_TO_HSV_CONVERT_MACROS_SVH

`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgb_to_hsv_convert: property check failed");
`define RHC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rgb_to_hsv_convert: forbidden condition seen");
`else
`define RHC_ASSERT(lbl, prop)
`define RHC_NEVER(lbl, expr)
`endif

`endif

>>> rtl/rhc_pkg.sv
package rhc_pkg;

  localparam int COMPONENT_BITS = 12;
  localparam int HUE_BITS       = 12;
  // hue numerator and six times delta both stay below 6 * 2^COMPONENT_BITS
  localparam int NUM_BITS       = COMPONENT_BITS + 3;
  localparam int DIV_STAGES     = (HUE_BITS > COMPONENT_BITS) ? HUE_BITS : COMPONENT_BITS;

  typedef logic [COMPONENT_BITS-1:0] comp_t;
  typedef logic [HUE_BITS-1:0]       hue_t;
  typedef logic [NUM_BITS-1:0]       num_t;

  typedef enum logic [2:0] {
    MAX_RED   = 3'b001,
    MAX_GREEN = 3'b010,
    MAX_BLUE  = 3'b100
  } max_sel_t;

  typedef struct packed {
    comp_t    red;
    comp_t    green;
    comp_t    blue;
    comp_t    mx;
    comp_t    mn;
    max_sel_t sel;
  } front_t;

  typedef struct packed {
    num_t  rem_h;
    num_t  sixd;
    hue_t  q_h;
    comp_t rem_s;
    comp_t low_s;
    comp_t q_s;
    comp_t mx;
    logic  grey;
  } div_stage_t;

  typedef struct packed {
    hue_t  hue;
    comp_t sat;
    comp_t bri;
  } hsv_t;

endpackage

>>> rtl/rhc_rgb_if.sv
interface rhc_rgb_if;
  import rhc_pkg::*;

  logic  valid;
  logic  ready;
  comp_t red_in;
  comp_t green_in;
  comp_t blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

>>> rtl/rhc_hsv_if.sv
interface rhc_hsv_if;
  import rhc_pkg::*;

  logic  valid;
  logic  ready;
  hue_t  hue_out;
  comp_t saturation_out;
  comp_t brightness_out;

  modport source(output valid, output hue_out, output saturation_out,
                 output brightness_out, input ready);
  modport sink(input valid, input hue_out, input saturation_out,
               input brightness_out, output ready);
endinterface

>>> rtl/rgb_to_hsv_convert.sv
// channel   direction  fields
// in_ch     sink       red_in, green_in, blue_in      (12 bits each)
// out_ch    source     hue_out, saturation_out, brightness_out
//
// One pixel a cycle while the skid register is empty; a front end, then
// DIV_STAGES divider stages (DIV_STAGES = 12, one quotient bit of each divider
// per stage), then one output register before the presented result.
// Synchronous active-low reset clears the valid bits only, the skid flag included.
// A stalled output parks one word in a skid register; in_ch.ready is that
// register's empty flag, so the whole pipeline holds until it drains.
`include "rgb_to_hsv_convert_macros.svh"

module rgb_to_hsv_convert (
  input logic       clk,
  input logic       rst_n,
  rhc_rgb_if.sink   in_ch,
  rhc_hsv_if.source out_ch
);
  import rhc_pkg::*;

  logic       en;
  logic       front_valid;
  div_stage_t front_stage;
  logic       div_valid;
  hsv_t       div_data;

  assign in_ch.ready = en;

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .red       (in_ch.red_in),
    .green     (in_ch.green_in),
    .blue      (in_ch.blue_in),
    .out_valid (front_valid),
    .out_stage (front_stage)
  );

  rhc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_valid),
    .in_stage  (front_stage),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  rhc_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (div_valid & en),
    .push_data  (div_data),
    .push_ready (en),
    .out_ch     (out_ch)
  );

  // a black pixel is grey
  `RHC_ASSERT(a_black_is_grey, out_ch.valid && out_ch.brightness_out == '0 |-> out_ch.hue_out == '0 && out_ch.saturation_out == '0)
  // a held skid word implies a presented result
  `RHC_NEVER(a_skid_needs_out, !in_ch.ready && !out_ch.valid)
  // the input side stalls only after the output side refused a word
  `RHC_ASSERT(a_stall_cause, $fell(in_ch.ready) |-> $past(out_ch.valid && !out_ch.ready))

endmodule

>>> rtl/rhc_front.sv
module rhc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rhc_pkg::comp_t      red,
  input  rhc_pkg::comp_t      green,
  input  rhc_pkg::comp_t      blue,
  output logic                out_valid,
  output rhc_pkg::div_stage_t out_stage
);
  import rhc_pkg::*;

  localparam int WW = NUM_BITS + 1;

  front_t     s1_nxt, s1_r;
  logic       v1_r;
  div_stage_t s2_nxt, s2_r;
  logic       v2_r;

  comp_t                   d;
  num_t                    sixd;
  comp_t                   op_a, op_b;
  num_t                    base;
  logic [COMPONENT_BITS:0] diff;
  logic [WW-1:0]           diff_w, wrap_w, n_w;
  logic [2*COMPONENT_BITS-1:0] satnum;

  // stage 1: largest, smallest and which component wins
  always_comb begin
    s1_nxt.red   = red;
    s1_nxt.green = green;
    s1_nxt.blue  = blue;
    priority if (red >= green && red >= blue) begin
      s1_nxt.sel = MAX_RED;
    end else if (green >= blue) begin
      s1_nxt.sel = MAX_GREEN;
    end else begin
      s1_nxt.sel = MAX_BLUE;
    end
    unique case (s1_nxt.sel)
      MAX_RED:   s1_nxt.mx = red;
      MAX_GREEN: s1_nxt.mx = green;
      MAX_BLUE:  s1_nxt.mx = blue;
      default:   s1_nxt.mx = red;
    endcase
    if (red <= green) begin
      s1_nxt.mn = (red <= blue) ? red : blue;
    end else begin
      s1_nxt.mn = (green <= blue) ? green : blue;
    end
  end

  // stage 2: delta, hue numerator folded into [0, 6d), saturation dividend
  always_comb begin
    d    = s1_r.mx - s1_r.mn;
    sixd = NUM_BITS'({d, 2'b00}) + NUM_BITS'({d, 1'b0});
    unique case (s1_r.sel)
      MAX_RED: begin
        op_a = s1_r.green;
        op_b = s1_r.blue;
        base = '0;
      end
      MAX_GREEN: begin
        op_a = s1_r.blue;
        op_b = s1_r.red;
        base = NUM_BITS'({d, 1'b0});
      end
      MAX_BLUE: begin
        op_a = s1_r.red;
        op_b = s1_r.green;
        base = NUM_BITS'({d, 2'b00});
      end
      default: begin
        op_a = s1_r.green;
        op_b = s1_r.blue;
        base = '0;
      end
    endcase
    diff   = {1'b0, op_a} - {1'b0, op_b};
    diff_w = {{(WW-COMPONENT_BITS-1){diff[COMPONENT_BITS]}}, diff};
    // only the red sector can go negative: wrap it by one full turn
    wrap_w = (s1_r.sel == MAX_RED && diff[COMPONENT_BITS]) ? WW'(sixd) : '0;
    n_w    = WW'(base) + diff_w + wrap_w;
    // delta * (2^C - 1)
    satnum = {d, {COMPONENT_BITS{1'b0}}} - {{COMPONENT_BITS{1'b0}}, d};

    s2_nxt.rem_h = n_w[NUM_BITS-1:0];
    s2_nxt.sixd  = sixd;
    s2_nxt.q_h   = '0;
    s2_nxt.rem_s = satnum[2*COMPONENT_BITS-1:COMPONENT_BITS];
    s2_nxt.low_s = satnum[COMPONENT_BITS-1:0];
    s2_nxt.q_s   = '0;
    s2_nxt.mx    = s1_r.mx;
    s2_nxt.grey  = (d == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_stage = s2_r;

endmodule

>>> rtl/rhc_div_pipe.sv
module rhc_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rhc_pkg::div_stage_t in_stage,
  output logic                out_valid,
  output rhc_pkg::hsv_t       out_data
);
  import rhc_pkg::*;

  div_stage_t stg_r [DIV_STAGES];
  logic       v_r   [DIV_STAGES];
  div_stage_t last;

  // one restoring step of each division per stage, quotient bits MSB first
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
    div_stage_t            cur, nxt;
    logic                  cur_v;
    logic [NUM_BITS:0]     t_h;
    logic [COMPONENT_BITS:0] t_s;

    if (i == 0) begin : g_first
      assign cur   = in_stage;
      assign cur_v = in_valid;
    end else begin : g_next
      assign cur   = stg_r[i-1];
      assign cur_v = v_r[i-1];
    end

    always_comb begin
      nxt = cur;
      t_h = {cur.rem_h, 1'b0};
      t_s = {cur.rem_s, cur.low_s[COMPONENT_BITS-1]};
      if (i < HUE_BITS) begin
        if (t_h >= {1'b0, cur.sixd}) begin
          nxt.rem_h = NUM_BITS'(t_h - {1'b0, cur.sixd});
          nxt.q_h   = {cur.q_h[HUE_BITS-2:0], 1'b1};
        end else begin
          nxt.rem_h = t_h[NUM_BITS-1:0];
          nxt.q_h   = {cur.q_h[HUE_BITS-2:0], 1'b0};
        end
      end
      if (i < COMPONENT_BITS) begin
        nxt.low_s = {cur.low_s[COMPONENT_BITS-2:0], 1'b0};
        if (t_s >= {1'b0, cur.mx}) begin
          nxt.rem_s = COMPONENT_BITS'(t_s - {1'b0, cur.mx});
          nxt.q_s   = {cur.q_s[COMPONENT_BITS-2:0], 1'b1};
        end else begin
          nxt.rem_s = t_s[COMPONENT_BITS-1:0];
          nxt.q_s   = {cur.q_s[COMPONENT_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[i] <= nxt;
      end
    end
  end

  assign last      = stg_r[DIV_STAGES-1];
  assign out_valid = v_r[DIV_STAGES-1];

  // grey pixels divide by zero: force hue and saturation to zero
  always_comb begin
    out_data.hue = last.grey ? '0 : last.q_h;
    out_data.sat = last.grey ? '0 : last.q_s;
    out_data.bri = last.mx;
  end

endmodule

>>> rtl/rhc_out_buf.sv
module rhc_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  rhc_pkg::hsv_t   push_data,
  output logic            push_ready,
  rhc_hsv_if.source       out_ch
);
  import rhc_pkg::*;

  hsv_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  assign push_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!skid_valid_r) begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= push_valid;
      end else if (push_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      // drain the skid word into the output register
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      if (!out_valid_r || out_ch.ready) begin
        out_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (out_ch.ready) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hue_out        = out_r.hue;
  assign out_ch.saturation_out = out_r.sat;
  assign out_ch.brightness_out = out_r.bri;

endmodule
